// ----- rtl/core/rtm_pkg.sv -----
// Package for the radix tree map: request and response item types,
// action and status codes, and the sequencer state type.
// No dependencies; the top level and the checker in rtl/core import it.
package rtm_pkg;

  localparam logic ACTION_GET = 1'b0;
  localparam logic ACTION_SET = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_NODES = 1'b1;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int BYTE_W  = 8;

  typedef struct packed {
    logic               action;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] found_value;
    logic               status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_FINISH
  } rtm_state_t;

endpackage

// ----- rtl/core/rtm_ram.sv -----
// Generic single-port RAM with a registered read port.
// Standalone; no package dependency.
module rtm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/radix_tree_map_top.sv -----
// Radix tree map top level: a sequencer walking a 256-way tree held in one node RAM.
// Each level presents the slot address in S_ISSUE and takes the registered read data in
// S_WAIT (a store at the last level writes in S_ISSUE instead); S_FINISH then loads the
// response register. One item at a time: a new item is taken only in S_IDLE.
// Reset: synchronous; afterwards a clearing pass zeroes all NODE_COUNT*256 node RAM
// entries (16384 by default), one entry per cycle, with req_stall held high.
module radix_tree_map_top #(
  parameter int LEVELS     = 4,
  parameter int NODE_COUNT = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rtm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rtm_pkg::rsp_t rsp
);

  import rtm_pkg::*;

  // Node number width, pool counter width (it must hold NODE_COUNT itself),
  // level counter width and node RAM address width.
  localparam int NW       = $clog2(NODE_COUNT);
  localparam int FW       = $clog2(NODE_COUNT + 1);
  localparam int LW       = $clog2(LEVELS + 1);
  localparam int AW       = NW + BYTE_W;
  localparam int DEPTH    = NODE_COUNT * 256;
  localparam int WIN_W    = 64;
  // The key is zero-extended to 64 bits and aligned so that the byte for
  // level 0 sits at the top of the window; each level shifts one byte out.
  localparam int KeyShift = BYTE_W * (8 - LEVELS);

  rtm_state_t state, state_next;

  logic [LW-1:0]      lvl, lvl_next;
  logic [NW-1:0]      node, node_next;
  logic [FW-1:0]      nfree, nfree_next;
  logic [AW-1:0]      clr, clr_next;
  logic               action, action_next;
  logic [WIN_W-1:0]   kwin, kwin_next;
  logic [VALUE_W-1:0] value, value_next;
  logic [VALUE_W-1:0] found, found_next;
  logic               status, status_next;
  logic               rsp_valid_next;
  logic               rsp_load;
  logic               last;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;

  rtm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // The block takes a new item only when the sequencer is idle. The response
  // register separates the sides, so a waiting result does not block input.
  assign req_stall = (state != S_IDLE);
  assign last      = (lvl == LW'(LEVELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      nfree     <= FW'(1);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      nfree     <= nfree_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Per-item working registers and the response payload carry no reset.
  always_ff @(posedge clk) begin
    lvl    <= lvl_next;
    node   <= node_next;
    action <= action_next;
    kwin   <= kwin_next;
    value  <= value_next;
    found  <= found_next;
    status <= status_next;
    if (rsp_load) begin
      rsp.found_value <= found;
      rsp.status      <= status;
    end
  end

  always_comb begin
    state_next  = state;
    lvl_next    = lvl;
    node_next   = node;
    nfree_next  = nfree;
    clr_next    = clr;
    action_next = action;
    kwin_next   = kwin;
    value_next  = value;
    found_next  = found;
    status_next = status;
    rsp_load    = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = {node, kwin[WIN_W-1 -: BYTE_W]};
    ram_wdata   = value;

    case (state)
      S_CLEAR: begin
        // Zero the whole node RAM once after reset.
        ram_we    = 1'b1;
        ram_addr  = clr;
        ram_wdata = '0;
        clr_next  = clr + AW'(1);
        if (clr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          action_next = req.action;
          kwin_next   = WIN_W'(req.key) << KeyShift;
          value_next  = req.value;
          node_next   = '0;
          lvl_next    = '0;
          found_next  = '0;
          status_next = STATUS_DONE;
          state_next  = S_ISSUE;
        end
      end

      S_ISSUE: begin
        // Present the slot address. A store at the last level writes the
        // value here and is done; everything else reads the slot.
        if (last && action == ACTION_SET) begin
          ram_we     = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_WAIT;
        end
      end

      S_WAIT: begin
        // Read data of the slot addressed in the previous cycle is here now.
        if (last) begin
          found_next = ram_rdata;
          state_next = S_FINISH;
        end else if (ram_rdata == '0) begin
          if (action == ACTION_GET) begin
            state_next = S_FINISH;
          end else if (nfree >= FW'(NODE_COUNT)) begin
            status_next = STATUS_NO_NODES;
            state_next  = S_FINISH;
          end else begin
            // Take the next pool node and link it into the same slot.
            ram_we     = 1'b1;
            ram_wdata  = VALUE_W'(nfree);
            nfree_next = nfree + FW'(1);
            node_next  = nfree[NW-1:0];
            lvl_next   = lvl + LW'(1);
            kwin_next  = kwin << BYTE_W;
            state_next = S_ISSUE;
          end
        end else if (ram_rdata >= VALUE_W'(NODE_COUNT)) begin
          // A child number outside the pool ends the walk.
          status_next = (action == ACTION_SET) ? STATUS_NO_NODES : STATUS_DONE;
          state_next  = S_FINISH;
        end else begin
          node_next  = ram_rdata[NW-1:0];
          lvl_next   = lvl + LW'(1);
          kwin_next  = kwin << BYTE_W;
          state_next = S_ISSUE;
        end
      end

      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

// ----- rtl/core/rtm_checker.sv -----
// Port-level checker for the radix tree map top level, with its bind statement.
// Depends on rtm_pkg for the response item type.
module rtm_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rtm_pkg::rsp_t rsp
);

  import rtm_pkg::*;

  // A result that is held back keeps its valid and its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response item changed or was dropped");

  // The node memory is cleared after reset, so no item may enter right away.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request accepted during the clearing pass");

  // One item at a time: the block is busy in the cycle after it takes one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second item taken while a walk was in progress");

  // A walk passes at least through the address state and S_FINISH before the response
  // register is loaded, so no result can appear in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !$rose(rsp_valid))
    else $error("response appeared too early after an accepted item");

endmodule

bind radix_tree_map_top rtm_checker u_rtm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for radix_tree_map_top, the 256-way radix tree key/value map.
// It depends on rtl/core/rtm_pkg.sv for the item types and codes, and on the RTL top level.
// A shadow copy of the tree predicts every response item, which is checked in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtm_pkg::*;

  localparam int LEVELS     = 4;
  localparam int NODE_COUNT = 64;
  localparam int FANOUT     = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Request side: the testbench is the sender, the block drives req_stall.
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;

  // Response side: the block is the sender, the testbench drives rsp_stall.
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  radix_tree_map_top #(
    .LEVELS    (LEVELS),
    .NODE_COUNT(NODE_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // The period is 8 ns.
  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow tree. Every entry starts at zero, which in an interior node means "no child"
  // and in a leaf node means "empty". Node 0 is the root, so allocation starts at 1.
  bit [63:0]   tree_mem [NODE_COUNT*FANOUT];
  int unsigned next_node = 1;

  // Items waiting to be driven, and responses predicted but not yet seen.
  req_t pending_req [$];
  rsp_t predicted_rsp [$];
  // Keys that have been stored so far; lookups mostly go back to these.
  logic [KEY_W-1:0] stored_keys [$];

  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int errors        = 0;
  int lookups       = 0;
  int lookup_hits   = 0;
  int stores        = 0;
  int stores_failed = 0;

  // Walk the shadow tree exactly as the hardware should, one key byte per level with the
  // most significant byte first. Stores allocate missing interior nodes as they go; when
  // the pool is dry the store stops with a failure status and the nodes taken so far stay
  // linked. A child number beyond the pool counts as absent for a lookup and as a failure
  // for a store, although a correct tree never holds one.
  function automatic rsp_t walk_tree(input req_t item);
    rsp_t             res;
    logic [63:0]      wide_key;
    logic [63:0]      child;
    int unsigned      node;
    int unsigned      idx;
    res.found_value = '0;
    res.status      = STATUS_DONE;
    wide_key        = {32'h0, item.key};
    node            = 0;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      idx   = node * FANOUT + wide_key[8*(LEVELS-1-lvl) +: 8];
      child = tree_mem[idx];
      if (child == 0) begin
        if (item.action == ACTION_GET) begin
          return res;
        end
        if (next_node >= NODE_COUNT) begin
          res.status = STATUS_NO_NODES;
          return res;
        end
        child = 64'(next_node);
        next_node++;
        tree_mem[idx] = child;
      end
      if (child >= NODE_COUNT) begin
        if (item.action == ACTION_SET) begin
          res.status = STATUS_NO_NODES;
        end
        return res;
      end
      node = child[31:0];
    end
    idx = node * FANOUT + wide_key[7:0];
    if (item.action == ACTION_GET) begin
      res.found_value = tree_mem[idx];
    end else begin
      tree_mem[idx] = item.value;
    end
    return res;
  endfunction

  // Predict the response for an accepted item, keep some statistics, and queue it.
  task automatic record_prediction(input req_t item);
    rsp_t res;
    res = walk_tree(item);
    if (item.action == ACTION_GET) begin
      lookups++;
      if (res.found_value != 0) begin
        lookup_hits++;
      end
    end else begin
      stores++;
      if (res.status == STATUS_NO_NODES) begin
        stores_failed++;
      end
    end
    predicted_rsp.push_back(res);
  endtask

  task automatic queue_item(input logic act, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v);
    req_t item;
    item.action = act;
    item.key    = k;
    item.value  = v;
    pending_req.push_back(item);
    if (act == ACTION_SET) begin
      stored_keys.push_back(k);
    end
  endtask

  // Random traffic. By the time it starts the directed part has emptied the node pool,
  // so the leaf nodes that exist are those under the prefixes listed here. Most items
  // stay on those prefixes, so stores really land and lookups read them back. Prefix
  // 13_00_00 has a linked but empty level-one node, so stores there are refused. A tenth
  // of the items use a fully random key, which exercises every key bit and the refusals.
  task automatic queue_random_item();
    logic [23:0]        prefix;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    logic               act;
    int                 pick;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0:       prefix = 24'h000000;
      1:       prefix = 24'hFFFFFF;
      2:       prefix = 24'h000100;
      default: prefix = {8'($urandom_range(1, 19)), 16'h0000};
    endcase
    k = {prefix, 8'($urandom)};
    v = {$urandom, $urandom};
    case ($urandom_range(19))
      0:       v = '0;
      1:       v = '1;
      default: ;
    endcase
    if (pick < 40) begin
      act = ACTION_SET;
    end else if (pick < 80) begin
      act = ACTION_GET;
      if (stored_keys.size() > 0) begin
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end
    end else if (pick < 90) begin
      act = ACTION_GET;
    end else begin
      act = 1'($urandom);
      k   = $urandom;
    end
    queue_item(act, k, v);
  endtask

  // Hold the stimulus back until every queued item has been taken and every predicted
  // response has come back. This is also where the sender pauses with the block idle.
  task automatic drain();
    while (pending_req.size() != 0 || req_valid || predicted_rsp.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver. An item is taken at an edge where req_valid is high and req_stall is low.
  // A stalled item is held unchanged; otherwise the next item is offered unless the
  // sender decides to idle this cycle.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        record_prediction(req);
        void'(pending_req.pop_front());
      end
      if (!req_valid || !req_stall) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req       <= pending_req[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each response item taken is compared with the oldest prediction, field by
  // field. The stall for the next cycle is drawn at random.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (predicted_rsp.size() == 0) begin
          $display("%0t: response item with nothing pending, got found_value %h status %0d",
                   $time, rsp.found_value, rsp.status);
          errors++;
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp.found_value !== want.found_value) begin
            $display("%0t: found_value mismatch, expected %h, got %h",
                     $time, want.found_value, rsp.found_value);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp.status);
            errors++;
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Overall time limit, ample for the clearing pass after reset and for the slowest legal
  // run of the traffic below.
  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, paced like the first random phase.
    send_idle_pct = 23;
    rcv_idle_pct  = 50;

    // An empty tree answers zero at the first level, for both extreme keys.
    queue_item(ACTION_GET, 32'h0000_0000, 64'hDEAD_BEEF_0BAD_F00D);
    queue_item(ACTION_GET, 32'hFFFF_FFFF, '1);
    // First stores build whole paths (three nodes each); all-ones value and key extremes.
    queue_item(ACTION_SET, 32'h0000_0000, '1);
    queue_item(ACTION_GET, 32'h0000_0000, '0);
    queue_item(ACTION_SET, 32'hFFFF_FFFF, 64'h0000_0000_0000_0001);
    queue_item(ACTION_GET, 32'hFFFF_FFFF, '0);
    // A neighbour in the same leaf node needs no allocation.
    queue_item(ACTION_SET, 32'h0000_0001, 64'h8000_0000_0000_0000);
    // Missing child at the third level.
    queue_item(ACTION_GET, 32'h0000_0100, '0);
    // Storing zero clears the entry.
    queue_item(ACTION_SET, 32'h0000_0000, '0);
    queue_item(ACTION_GET, 32'h0000_0000, '0);
    // New branch below an existing first-level node takes two nodes.
    queue_item(ACTION_SET, 32'h0001_0000, 64'h0123_4567_89AB_CDEF);
    // Fill the pool: 18 new top bytes at three nodes each leave one node spare.
    for (int b = 1; b <= 18; b++) begin
      queue_item(ACTION_SET, {8'(b), 24'h0000AA}, {$urandom, $urandom});
    end
    // This store takes the last node and then runs dry; the node stays linked but empty.
    queue_item(ACTION_SET, 32'h1300_0000, 64'hFEDC_BA98_7654_3210);
    queue_item(ACTION_GET, 32'h1300_0000, '0);
    // With the pool exhausted, stores on existing paths still work.
    queue_item(ACTION_SET, 32'h0000_0002, 64'h5555_AAAA_5555_AAAA);
    queue_item(ACTION_GET, 32'h0000_0001, '0);
    drain();

    // Random part in three pacing modes; each is split in two with a full drain between.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          rcv_idle_pct  = 50;
        end
        1: begin
          send_idle_pct = 50;
          rcv_idle_pct  = 23;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
        end
      endcase
      for (int half = 0; half < 2; half++) begin
        for (int n = 0; n < 135; n++) begin
          queue_random_item();
        end
        drain();
      end
    end

    // Leave room for any stray response after the last expected one.
    repeat (30) @(posedge clk);

    $display("Ran %0d lookups (%0d found a value) and %0d stores (%0d refused, pool empty),",
             lookups, lookup_hits, stores, stores_failed);
    $display("with sender and receiver stalls in both proportions and with none.");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
